// ===== rtl/svd_pkg.sv =====
// Shared types, constants and the quarter-wave sine table of the SVPWM duty calculator.
package svd_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PWM_PERIOD = 2'd0,
        CFG_MIN_DUTY   = 2'd1,
        CFG_MAX_DUTY   = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    localparam logic [15:0] PWM_PERIOD_RST = 16'd4200;
    localparam logic [15:0] MIN_DUTY_RST   = 16'd240;
    localparam logic [15:0] MAX_DUTY_RST   = 16'd1740;

    // sqrt(3)/2 in Q16
    localparam logic signed [17:0] SQRT3_HALF_Q16 = 18'sd56756;

    typedef logic [2:0] t_sector;
    localparam t_sector SEC_1 = 3'd1;
    localparam t_sector SEC_2 = 3'd2;
    localparam t_sector SEC_3 = 3'd3;
    localparam t_sector SEC_4 = 3'd4;
    localparam t_sector SEC_5 = 3'd5;
    localparam t_sector SEC_6 = 3'd6;

    // trig stage -> vector stage
    typedef struct packed {
        t_sector            sector;
        logic [15:0]        mt;
        logic signed [16:0] s;
        logic signed [16:0] c;
    } t_trig;

    // vector stage -> time stage
    typedef struct packed {
        t_sector     sector;
        logic [15:0] mt;
        logic [15:0] first;
        logic [15:0] second;
    } t_vec;

    // time stage -> phase stage
    typedef struct packed {
        t_sector     sector;
        logic [15:0] ta;
        logic [15:0] tb;
        logic [13:0] tc;
    } t_time;

    // result item
    typedef struct packed {
        logic [15:0] w_duty;
        logic [15:0] v_duty;
        logic [15:0] u_duty;
        t_sector     sector;
    } t_result;

    // trunc(sin(d) * 32768), saturated at 32767, for d = 0..90
    function automatic logic [14:0] sin_rom(input logic [6:0] idx);
        logic [14:0] v;
        unique case (idx)
            7'd0:  v = 15'd0;     7'd1:  v = 15'd571;   7'd2:  v = 15'd1143;
            7'd3:  v = 15'd1714;  7'd4:  v = 15'd2285;  7'd5:  v = 15'd2855;
            7'd6:  v = 15'd3425;  7'd7:  v = 15'd3993;  7'd8:  v = 15'd4560;
            7'd9:  v = 15'd5126;  7'd10: v = 15'd5690;  7'd11: v = 15'd6252;
            7'd12: v = 15'd6812;  7'd13: v = 15'd7371;  7'd14: v = 15'd7927;
            7'd15: v = 15'd8480;  7'd16: v = 15'd9032;  7'd17: v = 15'd9580;
            7'd18: v = 15'd10125; 7'd19: v = 15'd10668; 7'd20: v = 15'd11207;
            7'd21: v = 15'd11743; 7'd22: v = 15'd12275; 7'd23: v = 15'd12803;
            7'd24: v = 15'd13327; 7'd25: v = 15'd13848; 7'd26: v = 15'd14364;
            7'd27: v = 15'd14876; 7'd28: v = 15'd15383; 7'd29: v = 15'd15886;
            7'd30: v = 15'd16384; 7'd31: v = 15'd16876; 7'd32: v = 15'd17364;
            7'd33: v = 15'd17846; 7'd34: v = 15'd18323; 7'd35: v = 15'd18794;
            7'd36: v = 15'd19260; 7'd37: v = 15'd19720; 7'd38: v = 15'd20173;
            7'd39: v = 15'd20621; 7'd40: v = 15'd21062; 7'd41: v = 15'd21497;
            7'd42: v = 15'd21926; 7'd43: v = 15'd22347; 7'd44: v = 15'd22762;
            7'd45: v = 15'd23170; 7'd46: v = 15'd23571; 7'd47: v = 15'd23964;
            7'd48: v = 15'd24351; 7'd49: v = 15'd24730; 7'd50: v = 15'd25101;
            7'd51: v = 15'd25465; 7'd52: v = 15'd25821; 7'd53: v = 15'd26169;
            7'd54: v = 15'd26509; 7'd55: v = 15'd26841; 7'd56: v = 15'd27165;
            7'd57: v = 15'd27481; 7'd58: v = 15'd27788; 7'd59: v = 15'd28087;
            7'd60: v = 15'd28377; 7'd61: v = 15'd28659; 7'd62: v = 15'd28932;
            7'd63: v = 15'd29196; 7'd64: v = 15'd29451; 7'd65: v = 15'd29697;
            7'd66: v = 15'd29935; 7'd67: v = 15'd30163; 7'd68: v = 15'd30381;
            7'd69: v = 15'd30591; 7'd70: v = 15'd30791; 7'd71: v = 15'd30982;
            7'd72: v = 15'd31164; 7'd73: v = 15'd31336; 7'd74: v = 15'd31498;
            7'd75: v = 15'd31651; 7'd76: v = 15'd31794; 7'd77: v = 15'd31928;
            7'd78: v = 15'd32051; 7'd79: v = 15'd32165; 7'd80: v = 15'd32270;
            7'd81: v = 15'd32364; 7'd82: v = 15'd32449; 7'd83: v = 15'd32523;
            7'd84: v = 15'd32588; 7'd85: v = 15'd32643; 7'd86: v = 15'd32688;
            7'd87: v = 15'd32723; 7'd88: v = 15'd32748; 7'd89: v = 15'd32763;
            7'd90: v = 15'd32767;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // Q15 sine of an angle 0..359 from the quarter-wave table
    function automatic logic signed [16:0] sin_q15(input logic [8:0] a);
        logic [8:0]  idx;
        logic        neg;
        logic [14:0] mag;
        if (a <= 9'd90) begin
            idx = a;
            neg = 1'b0;
        end else if (a <= 9'd180) begin
            idx = 9'd180 - a;
            neg = 1'b0;
        end else if (a <= 9'd270) begin
            idx = a - 9'd180;
            neg = 1'b1;
        end else begin
            idx = 9'd360 - a;
            neg = 1'b1;
        end
        mag = sin_rom(idx[6:0]);
        return neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    endfunction

endpackage

// ===== rtl/svd_trig.sv =====
// Angle reduction, sector, period scaling and sine/cosine lookup (two stages).
module svd_trig (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [15:0]          i_pwm_period,
    input  logic                 i_vld,
    output logic                 o_rdy,
    input  logic [8:0]           i_angle_deg,
    input  logic [15:0]          i_modulation,
    output logic                 o_vld,
    input  logic                 i_rdy,
    output svd_pkg::t_trig       o_data
);
    import svd_pkg::*;

    logic        r_vld0, r_vld1;
    logic        rdy0, rdy1;
    logic [8:0]  r_a, r_ca;
    t_sector     r_sector;
    logic [15:0] r_mt;
    t_trig       r_out;

    logic [8:0]  a;
    logic [9:0]  ca_sum;
    logic [8:0]  ca;
    t_sector     sector;
    logic [31:0] mprod;

    assign rdy1  = !r_vld1 || i_rdy;
    assign rdy0  = !r_vld0 || rdy1;
    assign o_rdy = rdy0;
    assign o_vld = r_vld1;
    assign o_data = r_out;

    always_comb begin
        a      = (i_angle_deg >= 9'd360) ? i_angle_deg - 9'd360 : i_angle_deg;
        ca_sum = {1'b0, a} + 10'd90;
        ca     = (ca_sum >= 10'd360) ? 9'(ca_sum - 10'd360) : ca_sum[8:0];
        priority if (a < 9'd60)  sector = SEC_1;
        else if (a < 9'd120)     sector = SEC_2;
        else if (a < 9'd180)     sector = SEC_3;
        else if (a < 9'd240)     sector = SEC_4;
        else if (a < 9'd300)     sector = SEC_5;
        else                     sector = SEC_6;
        mprod  = i_modulation * i_pwm_period;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
        end else begin
            if (rdy0) r_vld0 <= i_vld;
            if (rdy1) r_vld1 <= r_vld0;
        end
        if (rdy0 && i_vld) begin
            r_a      <= a;
            r_ca     <= ca;
            r_sector <= sector;
            r_mt     <= mprod[31:16];
        end
        if (rdy1 && r_vld0) begin
            r_out.sector <= r_sector;
            r_out.mt     <= r_mt;
            r_out.s      <= sin_q15(r_a);
            r_out.c      <= sin_q15(r_ca);
        end
    end

endmodule

// ===== rtl/svd_vector.sv =====
// sqrt(3)/2 cosine product, x/y/z terms and per-sector active term pick (two stages).
module svd_vector (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    output logic           o_rdy,
    input  svd_pkg::t_trig i_data,
    output logic           o_vld,
    input  logic           i_rdy,
    output svd_pkg::t_vec  o_data
);
    import svd_pkg::*;

    logic               r_vld0, r_vld1;
    logic               rdy0, rdy1;
    t_sector            r_sector;
    logic [15:0]        r_mt;
    logic signed [16:0] r_s, r_k;
    t_vec               r_out;

    logic signed [34:0] kprod;
    logic signed [16:0] half_s;
    logic signed [17:0] x, y, z, first, second;

    assign rdy1   = !r_vld1 || i_rdy;
    assign rdy0   = !r_vld0 || rdy1;
    assign o_rdy  = rdy0;
    assign o_vld  = r_vld1;
    assign o_data = r_out;

    always_comb begin
        kprod  = SQRT3_HALF_Q16 * i_data.c;
        half_s = r_s >>> 1;
        x      = {r_s[16], r_s};
        y      = {half_s[16], half_s} + {r_k[16], r_k};
        z      = {half_s[16], half_s} - {r_k[16], r_k};
        unique case (r_sector)
            SEC_1:   begin first = -z; second = x;  end
            SEC_2:   begin first = z;  second = y;  end
            SEC_3:   begin first = x;  second = -y; end
            SEC_4:   begin first = -x; second = z;  end
            SEC_5:   begin first = -y; second = -z; end
            default: begin first = y;  second = -x; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
        end else begin
            if (rdy0) r_vld0 <= i_vld;
            if (rdy1) r_vld1 <= r_vld0;
        end
        if (rdy0 && i_vld) begin
            r_sector <= i_data.sector;
            r_mt     <= i_data.mt;
            r_s      <= i_data.s;
            r_k      <= kprod[32:16];   // floor shift
        end
        if (rdy1 && r_vld0) begin
            r_out.sector <= r_sector;
            r_out.mt     <= r_mt;
            r_out.first  <= first[17]  ? 16'd0 : first[15:0];
            r_out.second <= second[17] ? 16'd0 : second[15:0];
        end
    end

endmodule

// ===== rtl/svd_times.sv =====
// Active times ta/tb and the zero-vector time tc (two stages).
module svd_times (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [15:0]    i_pwm_period,
    input  logic           i_vld,
    output logic           o_rdy,
    input  svd_pkg::t_vec  i_data,
    output logic           o_vld,
    input  logic           i_rdy,
    output svd_pkg::t_time o_data
);
    import svd_pkg::*;

    logic        r_vld0, r_vld1;
    logic        rdy0, rdy1;
    t_sector     r_sector;
    logic [15:0] r_ta, r_tb;
    t_time       r_out;

    logic [31:0] ta_prod, tb_prod;
    logic [16:0] sum;
    logic [16:0] half;
    logic [16:0] diff;
    logic [13:0] tc;

    assign rdy1   = !r_vld1 || i_rdy;
    assign rdy0   = !r_vld0 || rdy1;
    assign o_rdy  = rdy0;
    assign o_vld  = r_vld1;
    assign o_data = r_out;

    always_comb begin
        ta_prod = i_data.mt * i_data.first;
        tb_prod = i_data.mt * i_data.second;
        sum     = {1'b0, r_ta} + {1'b0, r_tb};
        half    = {2'b00, i_pwm_period[15:1]};
        diff    = half - sum;
        // negative zero-vector time saturates at zero
        tc      = (half > sum) ? diff[14:1] : 14'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
        end else begin
            if (rdy0) r_vld0 <= i_vld;
            if (rdy1) r_vld1 <= r_vld0;
        end
        if (rdy0 && i_vld) begin
            r_sector <= i_data.sector;
            r_ta     <= ta_prod[31:16];
            r_tb     <= tb_prod[31:16];
        end
        if (rdy1 && r_vld0) begin
            r_out.sector <= r_sector;
            r_out.ta     <= r_ta;
            r_out.tb     <= r_tb;
            r_out.tc     <= tc;
        end
    end

endmodule

// ===== rtl/svd_phase.sv =====
// Centered compare values, phase mapping and duty clamping; last stage is the output register.
module svd_phase (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [15:0]      i_min_duty,
    input  logic [15:0]      i_max_duty,
    input  logic             i_vld,
    output logic             o_rdy,
    input  svd_pkg::t_time   i_data,
    output logic             o_vld,
    input  logic             i_rdy,
    output svd_pkg::t_result o_data
);
    import svd_pkg::*;

    logic        r_vld0, r_vld1;
    logic        rdy0, rdy1;
    t_sector     r_sector;
    logic [17:0] r_u, r_v, r_w;
    t_result     r_out;

    logic [17:0] tc, tbo, tao, u, v, w;

    function automatic logic [15:0] clamp_duty(input logic [17:0] d,
                                               input logic [15:0] lo,
                                               input logic [15:0] hi);
        logic [17:0] t;
        t = (d < {2'b00, lo}) ? {2'b00, lo} : d;
        t = (t > {2'b00, hi}) ? {2'b00, hi} : t;
        return t[15:0];
    endfunction

    assign rdy1   = !r_vld1 || i_rdy;
    assign rdy0   = !r_vld0 || rdy1;
    assign o_rdy  = rdy0;
    assign o_vld  = r_vld1;
    assign o_data = r_out;

    always_comb begin
        tc  = {4'd0, i_data.tc};
        tbo = tc + {2'b00, i_data.tb};
        tao = tbo + {2'b00, i_data.ta};
        unique case (i_data.sector)
            SEC_1:   begin u = tao; v = tbo; w = tc;  end
            SEC_2:   begin u = tbo; v = tao; w = tc;  end
            SEC_3:   begin u = tc;  v = tao; w = tbo; end
            SEC_4:   begin u = tc;  v = tbo; w = tao; end
            SEC_5:   begin u = tbo; v = tc;  w = tao; end
            default: begin u = tao; v = tc;  w = tbo; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
        end else begin
            if (rdy0) r_vld0 <= i_vld;
            if (rdy1) r_vld1 <= r_vld0;
        end
        if (rdy0 && i_vld) begin
            r_sector <= i_data.sector;
            r_u      <= u;
            r_v      <= v;
            r_w      <= w;
        end
        if (rdy1 && r_vld0) begin
            r_out.sector <= r_sector;
            r_out.u_duty <= clamp_duty(r_u, i_min_duty, i_max_duty);
            r_out.v_duty <= clamp_duty(r_v, i_min_duty, i_max_duty);
            r_out.w_duty <= clamp_duty(r_w, i_min_duty, i_max_duty);
        end
    end

endmodule

// ===== rtl/svpwm_duty_calculator.sv =====
// Top level: seven-segment space vector PWM duty calculator.
//
// Usage: each input transfer on the s_axis side carries a vector angle in
// whole degrees (360..511 wrap modulo 360) and a Q16 modulation index. Each
// one yields exactly one output transfer on the m_axis side with the sector
// number 1..6 and the three clamped phase compare values, in input order.
// The configuration port writes pwm_period, min_duty and max_duty; write
// them only while no transfer is in flight.
// Pipeline: eight register stages lie between an input transfer and its
// output. Throughput: one transfer per cycle unless the output stalls;
// each stage holds its own valid bit. The stage count is set by the three
// multiplier ranks and the sine table.
// Reset (synchronous, active low): all stages empty, the registers return
// to 4200 / 240 / 1740.
// Stall: when i_m_axis_tready is low the result holds on the output and the
// stages behind it keep filling their empty slots; o_s_axis_tready drops
// only once every stage is occupied.
module svpwm_duty_calculator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [8:0] angle_deg, [24:9] modulation, rest zero
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata   // [2:0] sector, [18:3] u_duty, [34:19] v_duty,
                                         // [50:35] w_duty, rest zero
);
    import svd_pkg::*;

    logic [15:0] r_pwm_period, r_min_duty, r_max_duty;

    logic    trig_vld, trig_rdy;
    t_trig   trig_data;
    logic    vec_vld, vec_rdy;
    t_vec    vec_data;
    logic    time_vld, time_rdy;
    t_time   time_data;
    t_result res;

    // Configuration registers; unused index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period <= PWM_PERIOD_RST;
            r_min_duty   <= MIN_DUTY_RST;
            r_max_duty   <= MAX_DUTY_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_PWM_PERIOD: r_pwm_period <= i_cfg_wdata;
                CFG_MIN_DUTY:   r_min_duty   <= i_cfg_wdata;
                CFG_MAX_DUTY:   r_max_duty   <= i_cfg_wdata;
                CFG_UNUSED:     ;
            endcase
        end
    end

    // Stages 1-2: angle, sector, modulation*period, sine and cosine
    svd_trig u_trig (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pwm_period (r_pwm_period),
        .i_vld        (i_s_axis_tvalid),
        .o_rdy        (o_s_axis_tready),
        .i_angle_deg  (i_s_axis_tdata[8:0]),
        .i_modulation (i_s_axis_tdata[24:9]),
        .o_vld        (trig_vld),
        .i_rdy        (trig_rdy),
        .o_data       (trig_data)
    );

    // Stages 3-4: x/y/z and the two active terms
    svd_vector u_vector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (trig_vld),
        .o_rdy   (trig_rdy),
        .i_data  (trig_data),
        .o_vld   (vec_vld),
        .i_rdy   (vec_rdy),
        .o_data  (vec_data)
    );

    // Stages 5-6: ta, tb, tc
    svd_times u_times (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pwm_period (r_pwm_period),
        .i_vld        (vec_vld),
        .o_rdy        (vec_rdy),
        .i_data       (vec_data),
        .o_vld        (time_vld),
        .i_rdy        (time_rdy),
        .o_data       (time_data)
    );

    // Stages 7-8: compare values, phase map, clamp, output register
    svd_phase u_phase (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_min_duty (r_min_duty),
        .i_max_duty (r_max_duty),
        .i_vld      (time_vld),
        .o_rdy      (time_rdy),
        .i_data     (time_data),
        .o_vld      (o_m_axis_tvalid),
        .i_rdy      (i_m_axis_tready),
        .o_data     (res)
    );

    assign o_m_axis_tdata = {5'd0, res};

    // Empty output stage means every stage upstream can advance
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while output stage empty");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (res.sector >= SEC_1 && res.sector <= SEC_6))
        else $error("sector out of range");

    a_duty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (res.u_duty <= r_max_duty && res.v_duty <= r_max_duty
                             && res.w_duty <= r_max_duty))
        else $error("duty above max_duty");

    a_duty_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_min_duty <= r_max_duty) |->
        (res.u_duty >= r_min_duty && res.v_duty >= r_min_duty
         && res.w_duty >= r_min_duty))
        else $error("duty below min_duty");

endmodule

// ===== dv/svpwm_duty_calculator_tb.sv =====
// Self-checking stream testbench for the SVPWM duty calculator, with a scoreboard class.
`timescale 1ns / 100ps

module svpwm_duty_calculator_tb;
    import svd_pkg::*;

    localparam int     CLK_HALF     = 5;
    localparam int     RST_CYCLES   = 7;
    localparam int     END_SETTLE   = 24;      // margin over the block latency
    localparam int     CYCLE_LIMIT  = 400000;  // hang guard, well above the slowest correct run
    localparam int     LONG_HOLD    = 120;     // receiver hold-off that fills the pipe
    localparam longint SQRT3_OVER_2 = 56756;   // sqrt(3)/2 in Q16

    // ------------------------------------------------------------------
    // Expected duty model: its own register copy and sine table, a FIFO
    // of expected results in transfer order, and the field compare.
    // ------------------------------------------------------------------
    class duty_scoreboard;
        logic [15:0] period;
        logic [15:0] dmin;
        logic [15:0] dmax;
        int          qsine [91];
        t_result     pending_duties [$];
        int          errors;
        int          n_checked;

        function new();
            qsine = '{
                    0,   571,  1143,  1714,  2285,  2855,  3425,  3993,  4560,  5126,
                 5690,  6252,  6812,  7371,  7927,  8480,  9032,  9580, 10125, 10668,
                11207, 11743, 12275, 12803, 13327, 13848, 14364, 14876, 15383, 15886,
                16384, 16876, 17364, 17846, 18323, 18794, 19260, 19720, 20173, 20621,
                21062, 21497, 21926, 22347, 22762, 23170, 23571, 23964, 24351, 24730,
                25101, 25465, 25821, 26169, 26509, 26841, 27165, 27481, 27788, 28087,
                28377, 28659, 28932, 29196, 29451, 29697, 29935, 30163, 30381, 30591,
                30791, 30982, 31164, 31336, 31498, 31651, 31794, 31928, 32051, 32165,
                32270, 32364, 32449, 32523, 32588, 32643, 32688, 32723, 32748, 32763,
                32767};
            period    = PWM_PERIOD_RST;
            dmin      = MIN_DUTY_RST;
            dmax      = MAX_DUTY_RST;
            errors    = 0;
            n_checked = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] val);
            case (idx)
                CFG_PWM_PERIOD: period = val;
                CFG_MIN_DUTY:   dmin   = val;
                CFG_MAX_DUTY:   dmax   = val;
                default: ;
            endcase
        endfunction

        // Q15 sine for 0..359 from the quarter wave
        function longint sine_q15(int unsigned a);
            if (a <= 90)  return qsine[a];
            if (a <= 180) return qsine[180 - a];
            if (a <= 270) return -qsine[a - 180];
            return -qsine[360 - a];
        endfunction

        function longint active_time(longint term, longint mt);
            if (term < 0) term = 0;
            return ((mt * term) & 64'hFFFF_FFFF) >> 16;
        endfunction

        // raise to min first, then cut to max: max wins when min > max
        function logic [15:0] clamp_duty(longint d);
            if (d < dmin) d = dmin;
            if (d > dmax) d = dmax;
            return d[15:0];
        endfunction

        function t_result predict_duties(logic [8:0] angle, logic [15:0] modulation);
            int unsigned a;
            t_sector     sec;
            longint      s, c, k, x, y, z, first, second;
            longint      mt, ta, tb, half, tc, tbo, tao, u, v, w;
            t_result     r;
            a   = angle % 360;           // 360..511 wrap
            sec = t_sector'(a / 60 + 1);
            s   = sine_q15(a);
            c   = sine_q15((a + 90) % 360);
            k   = (SQRT3_OVER_2 * c) >>> 16;  // floors on negatives
            x   = s;
            y   = (s >>> 1) + k;
            z   = (s >>> 1) - k;
            case (sec)
                SEC_1:   begin first = -z; second = x;  end
                SEC_2:   begin first = z;  second = y;  end
                SEC_3:   begin first = x;  second = -y; end
                SEC_4:   begin first = -x; second = z;  end
                SEC_5:   begin first = -y; second = -z; end
                default: begin first = y;  second = -x; end
            endcase
            mt   = (longint'(modulation) * longint'(period)) >> 16;
            ta   = active_time(first, mt);
            tb   = active_time(second, mt);
            half = longint'(period) >> 1;
            // overmodulation: zero-vector time saturates at 0
            tc   = (half > ta + tb) ? ((half - ta - tb) >> 1) : 0;
            tbo  = tc + tb;
            tao  = tbo + ta;
            case (sec)
                SEC_1:   begin u = tao; v = tbo; w = tc;  end
                SEC_2:   begin u = tbo; v = tao; w = tc;  end
                SEC_3:   begin u = tc;  v = tao; w = tbo; end
                SEC_4:   begin u = tc;  v = tbo; w = tao; end
                SEC_5:   begin u = tbo; v = tc;  w = tao; end
                default: begin u = tao; v = tc;  w = tbo; end
            endcase
            r.sector = sec;
            r.u_duty = clamp_duty(u);
            r.v_duty = clamp_duty(v);
            r.w_duty = clamp_duty(w);
            return r;
        endfunction

        function void note_vector(logic [8:0] angle, logic [15:0] modulation);
            pending_duties.push_back(predict_duties(angle, modulation));
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_duties(t_result got);
            t_result want;
            n_checked++;
            if (pending_duties.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual sector %0d u %0d v %0d w %0d",
                         $time, got.sector, got.u_duty, got.v_duty, got.w_duty);
                errors++;
                return;
            end
            want = pending_duties.pop_front();
            compare_field("sector", want.sector, got.sector);
            compare_field("u_duty", want.u_duty, got.u_duty);
            compare_field("v_duty", want.v_duty, got.v_duty);
            compare_field("w_duty", want.w_duty, got.w_duty);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [15:0] i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;   // [8:0] angle_deg, [24:9] modulation
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [55:0] o_m_axis_tdata;   // [2:0] sector, [18:3] u, [34:19] v, [50:35] w

    svpwm_duty_calculator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    duty_scoreboard duties = new();

    // idling knobs, changed per phase by the stimulus process
    bit src_gaps_on   = 1'b1;
    bit sink_gaps_on  = 1'b1;
    bit long_hold_req = 1'b0;   // cleared by the sink once taken

    int n_sent        = 0;
    int n_settings    = 1;      // reset values count as the first
    int n_in_stalls   = 0;      // cycles input offered while block was full

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Run limit: anything past this is a hang.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side. While sink gaps are on, each transfer is preceded by a
    // random stall; the long hold-off is taken once on request while the
    // sender keeps pushing, so all eight stages fill and o_s_axis_tready drops.
    // Signals are sampled right after the edge, i.e. pre-edge values.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        i_m_axis_tready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = sink_gaps_on ? $urandom_range(0, 9) : 0;
            if (long_hold_req) begin
                gap           = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            duties.check_duties(t_result'(o_m_axis_tdata[50:0]));
        end
    end

    // ------------------------------------------------------------------
    // Input side tasks
    // ------------------------------------------------------------------

    // One input transfer; tvalid stays up when the next one follows at once.
    task automatic send_vector(logic [8:0] angle, logic [15:0] modulation);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, modulation, angle};
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            n_in_stalls++;
            @(posedge i_clk);
        end
        duties.note_vector(angle, modulation);
        n_sent++;
    endtask

    // Drop tvalid and wait for every expected result to come back.
    task automatic drain_pipe();
        i_s_axis_tvalid <= 1'b0;
        while (duties.pending_duties.size() != 0) @(posedge i_clk);
    endtask

    // Registers written back to back while idle; the unused index is
    // written too and must have no effect.
    task automatic program_regs(logic [15:0] period, logic [15:0] dmin, logic [15:0] dmax);
        t_cfg_idx    idx [4];
        logic [15:0] val [4];
        idx = '{CFG_PWM_PERIOD, CFG_MIN_DUTY, CFG_MAX_DUTY, CFG_UNUSED};
        val = '{period, dmin, dmax, 16'($urandom)};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= idx[i];
            i_cfg_wdata <= val[i];
            @(posedge i_clk);
            duties.set_reg(idx[i], val[i]);
        end
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Random vectors: mostly in-range angles, a share of wrapped ones;
    // modulation biased toward overmodulation and the field extremes.
    task automatic send_random_vectors(int count);
        logic [8:0]  angle;
        logic [15:0] modulation;
        for (int i = 0; i < count; i++) begin
            angle = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(360, 511))
                                                : 9'($urandom_range(0, 359));
            case ($urandom_range(0, 5))
                0, 1:    modulation = 16'($urandom);
                2, 3:    modulation = 16'($urandom_range(49152, 65535));
                4:       modulation = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default: modulation = 16'($urandom_range(0, 8191));
            endcase
            send_vector(angle, modulation);
        end
    endtask

    task automatic run_phase(logic [15:0] period, logic [15:0] dmin, logic [15:0] dmax,
                             bit src_on, bit sink_on, bit hold, int count);
        program_regs(period, dmin, dmax);
        src_gaps_on   = src_on;
        sink_gaps_on  = sink_on;
        long_hold_req = hold;
        send_random_vectors(count);
        drain_pipe();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        // sector edges, quarter points, wrap-around angles, zero and full
        // modulation, overmodulation near mid-sector
        int dir_angle [21] = '{0, 0, 30, 59, 60, 90, 119, 120, 180, 181, 240,
                               270, 299, 300, 330, 359, 360, 450, 511, 45, 210};
        int dir_mod   [21] = '{0, 65535, 65535, 40000, 65535, 65535, 30000, 50000,
                               65535, 12345, 65535, 65535, 20000, 65535, 65535,
                               65535, 65535, 30000, 65535, 32768, 1};
        logic [15:0] rnd_period, rnd_min;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = CFG_PWM_PERIOD;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part on the reset register values
        for (int i = 0; i < 21; i++) begin
            send_vector(9'(dir_angle[i]), 16'(dir_mod[i]));
        end
        drain_pipe();

        // widest period, no clamping
        run_phase(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b0, 300);
        // smallest period, back-to-back on both sides
        run_phase(16'd2, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0, 200);
        // min above max: every duty collapses to max
        run_phase(16'd4200, 16'd5000, 16'd100, 1'b1, 1'b1, 1'b0, 200);
        // sender flat out, receiver holds off long once
        run_phase(16'd20000, 16'd1000, 16'd9000, 1'b0, 1'b1, 1'b1, 300);
        // both limits at full scale
        run_phase(16'd3, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 150);
        // two random settings
        for (int p = 0; p < 2; p++) begin
            rnd_period = 16'($urandom_range(2, 65535));
            rnd_min    = 16'($urandom_range(0, rnd_period / 4));
            run_phase(rnd_period, rnd_min, 16'($urandom_range(rnd_min, 65535)),
                      1'b1, 1'b1, 1'b0, 250);
        end
        // back to the reset values, written explicitly
        run_phase(PWM_PERIOD_RST, MIN_DUTY_RST, MAX_DUTY_RST, 1'b1, 1'b0, 1'b0, 230);

        // let any stray output show up before the verdict
        repeat (END_SETTLE) @(posedge i_clk);

        $display("Sent %0d vectors under %0d register settings, %0d results checked.",
                 n_sent, n_settings, duties.n_checked);
        $display("Input side saw %0d cycles of backpressure; mismatches: %0d.",
                 n_in_stalls, duties.errors);
        if (duties.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
